// ===== rtl/mmtb_pkg.sv =====
// Package for the transposed-B matrix multiply unit.
// Sizes, request and register codes, and controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps
package mmtb_pkg;
	localparam int MAX_ROWS  = 8;
	localparam int MAX_COLS  = 8;
	localparam int MAX_DEPTH = 64;

	localparam int ROW_W   = 3;
	localparam int DEP_W   = 6;
	localparam int VAL_W   = 16;
	localparam int PROD_W  = 2 * VAL_W;
	localparam int SUM_W   = 38;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REQ_LOAD_A  = 2'd0;
	localparam logic [1:0] REQ_LOAD_B  = 2'd1;
	localparam logic [1:0] REQ_COMPUTE = 2'd2;

	localparam logic [1:0] REG_ROWS  = 2'd0;
	localparam logic [1:0] REG_COLS  = 2'd1;
	localparam logic [1:0] REG_DEPTH = 2'd2;

	typedef struct packed {
		logic [3:0] rows;
		logic [3:0] cols;
		logic [6:0] depth;
	} mmtb_cfg_t;

	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic             rd;
		logic             first;
		logic             last;
		logic             fin;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
		logic [DEP_W-1:0] dep;
	} mmtb_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_full;
	} mmtb_status_t;
endpackage

// ===== rtl/mmtb_regs.sv =====
// APB configuration registers: rows, columns and depth in use.
// Depends on mmtb_pkg.
`timescale 1ns / 1ps
module mmtb_regs import mmtb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output mmtb_cfg_t          cfg
);
	mmtb_cfg_t cfg_q;
	logic      wr;

	assign wr  = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows  <= 4'(MAX_ROWS);
			cfg_q.cols  <= 4'(MAX_COLS);
			cfg_q.depth <= 7'(MAX_DEPTH);
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_ROWS:  cfg_q.rows  <= pwdata[3:0];
				REG_COLS:  cfg_q.cols  <= pwdata[3:0];
				REG_DEPTH: cfg_q.depth <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ROWS:  prdata = {28'd0, cfg_q.rows};
			REG_COLS:  prdata = {28'd0, cfg_q.cols};
			REG_DEPTH: prdata = {25'd0, cfg_q.depth};
			default:   prdata = '0;
		endcase
	end
endmodule

// ===== rtl/mmtb_ctrl.sv =====
// Controller: accepts load/compute beats and sequences row, column and depth
// reads for the datapath. Depends on mmtb_pkg.
`timescale 1ns / 1ps
module mmtb_ctrl import mmtb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  mmtb_cfg_t        cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       req_type,
	input  logic [ROW_W-1:0] row_index,
	input  logic [DEP_W-1:0] depth_index,
	input  mmtb_status_t     st,
	output mmtb_cmd_t        cmd
);
	typedef enum logic {S_IDLE, S_RUN} state_t;

	state_t           state_q;
	logic [ROW_W-1:0] i_q, j_q, i_last_q, j_last_q;
	logic [DEP_W-1:0] k_q, k_last_q;
	logic [3:0]       rows_c, cols_c;
	logic [6:0]       depth_c;
	logic             accept, go;

	assign rows_c  = (cfg.rows == 4'd0) ? 4'd1 :
	                 (cfg.rows > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : cfg.rows;
	assign cols_c  = (cfg.cols == 4'd0) ? 4'd1 :
	                 (cfg.cols > 4'(MAX_COLS)) ? 4'(MAX_COLS) : cfg.cols;
	assign depth_c = (cfg.depth == 7'd0) ? 7'd1 :
	                 (cfg.depth > 7'(MAX_DEPTH)) ? 7'(MAX_DEPTH) : cfg.depth;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// a new element starts only once the accumulator and output register are free
	assign go = (state_q == S_RUN) && ((k_q != '0) || (!st.busy && !st.out_full));

	always_comb begin
		cmd       = '0;
		cmd.wr_a  = accept && (req_type == REQ_LOAD_A) &&
		            ({1'b0, row_index} < 4'(MAX_ROWS)) &&
		            ({1'b0, depth_index} < 7'(MAX_DEPTH));
		cmd.wr_b  = accept && (req_type == REQ_LOAD_B) &&
		            ({1'b0, row_index} < 4'(MAX_COLS)) &&
		            ({1'b0, depth_index} < 7'(MAX_DEPTH));
		cmd.rd    = go;
		cmd.first = go && (k_q == '0);
		cmd.last  = go && (k_q == k_last_q);
		cmd.fin   = go && (k_q == k_last_q) && (i_q == i_last_q) && (j_q == j_last_q);
		cmd.row   = i_q;
		cmd.col   = j_q;
		cmd.dep   = k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			i_last_q <= '0;
			j_last_q <= '0;
			k_last_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (req_type == REQ_COMPUTE)) begin
						i_last_q <= ROW_W'(rows_c - 4'd1);
						j_last_q <= ROW_W'(cols_c - 4'd1);
						k_last_q <= DEP_W'(depth_c - 7'd1);
						i_q      <= '0;
						j_q      <= '0;
						k_q      <= '0;
						state_q  <= S_RUN;
					end
				end
				S_RUN: begin
					if (go) begin
						if (k_q != k_last_q) begin
							k_q <= k_q + 1'b1;
						end else begin
							k_q <= '0;
							if (j_q != j_last_q) begin
								j_q <= j_q + 1'b1;
							end else begin
								j_q <= '0;
								if (i_q != i_last_q) begin
									i_q <= i_q + 1'b1;
								end else begin
									state_q <= S_IDLE;
								end
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.first |-> (!st.busy && !st.out_full))
		else $error("element started with datapath still occupied");
	a_fin_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> (state_q == S_IDLE))
		else $error("run did not end after final read");
endmodule

// ===== rtl/mmtb_datapath.sv =====
// Datapath: A and B element stores, registered read, multiplier, 38-bit
// accumulator and output register. Depends on mmtb_pkg.
`timescale 1ns / 1ps
module mmtb_datapath import mmtb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mmtb_cmd_t               cmd,
	input  logic [ROW_W-1:0]        row_index,
	input  logic [DEP_W-1:0]        depth_index,
	input  logic signed [VAL_W-1:0] element_value,
	output mmtb_status_t            st,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [ROW_W-1:0]        out_row,
	output logic [ROW_W-1:0]        out_col,
	output logic signed [SUM_W-1:0] product_sum,
	output logic                    last_result
);
	localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
	localparam int B_DEPTH = MAX_COLS * MAX_DEPTH;

	logic [VAL_W-1:0] a_mem [A_DEPTH];
	logic [VAL_W-1:0] b_mem [B_DEPTH];

	logic signed [VAL_W-1:0]  a_s1, b_s1;
	logic                     vld_s1, first_s1, last_s1, fin_s1;
	logic [ROW_W-1:0]         row_s1, col_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2, first_s2, last_s2, fin_s2;
	logic [ROW_W-1:0]         row_s2, col_s2;
	logic signed [SUM_W-1:0]  acc_q, sum;
	logic                     out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_a)
			a_mem[{row_index, depth_index}] <= element_value;
		if (cmd.rd)
			a_s1 <= a_mem[{cmd.row, cmd.dep}];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_b)
			b_mem[{row_index, depth_index}] <= element_value;
		if (cmd.rd)
			b_s1 <= b_mem[{cmd.col, cmd.dep}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		fin_s1   <= cmd.fin;
		row_s1   <= cmd.row;
		col_s1   <= cmd.col;
		prod_s2  <= a_s1 * b_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		fin_s2   <= fin_s1;
		row_s2   <= row_s1;
		col_s2   <= col_s1;
	end

	assign sum = (first_s2 ? '0 : acc_q) +
	             {{(SUM_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk) begin
		if (vld_s2)
			acc_q <= sum;
		if (vld_s2 && last_s2) begin
			product_sum <= sum;
			out_row     <= row_s2;
			out_col     <= col_s2;
			last_result <= fin_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (vld_s2 && last_s2)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid   = out_valid_q;
	assign st.busy     = vld_s1 || vld_s2;
	assign st.out_full = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && last_s2) |-> !out_valid_q)
		else $error("result written over a pending beat");
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && last_s2) |=> (out_valid_q && (out_row == $past(row_s2))))
		else $error("finished element not presented");
endmodule

// ===== rtl/matrix_multiply_transposed_b_unit.sv =====
// Top level: C = A x B-transposed on Q8.8 elements, exact Q22.16 sums.
// Load beats are accepted only while no compute runs; a compute beat yields
// rows*cols result beats. Each result element issues one store read per depth
// step, then passes the read, multiply and accumulate stages.
// The next element starts once the previous result beat is taken.
// Reset: registers return to 8/8/64, controller idles; stores hold garbage.
`timescale 1ns / 1ps
module matrix_multiply_transposed_b_unit import mmtb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [PDATA_W-1:0]      pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              req_type,
	input  logic [ROW_W-1:0]        row_index,
	input  logic [DEP_W-1:0]        depth_index,
	input  logic signed [VAL_W-1:0] element_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [ROW_W-1:0]        out_row,
	output logic [ROW_W-1:0]        out_col,
	output logic signed [SUM_W-1:0] product_sum,
	output logic                    last_result
);
	mmtb_cfg_t    cfg;
	mmtb_cmd_t    cmd;
	mmtb_status_t st;

	assign pready = 1'b1;

	mmtb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	mmtb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.row_index   (row_index),
		.depth_index (depth_index),
		.st          (st),
		.cmd         (cmd)
	);

	mmtb_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.row_index     (row_index),
		.depth_index   (depth_index),
		.element_value (element_value),
		.st            (st),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_row       (out_row),
		.out_col       (out_col),
		.product_sum   (product_sum),
		.last_result   (last_result)
	);
endmodule
